@@ hdl/sensor_frame_crc_check_convert_assert.svh @@
// Assertion macros for the sensor frame CRC check and convert block.
// Used by the port checker; no other dependencies.
`ifndef SENSOR_FRAME_CRC_CHECK_CONVERT_ASSERT_SVH
`define SENSOR_FRAME_CRC_CHECK_CONVERT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define SFCC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sfcc: assertion failed");

// Check a property on every rising clock edge, reset included.
`define SFCC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sfcc: assertion failed around reset");

`endif

@@ hdl/sfcc_pkg.sv @@
// Shared types, constants and the CRC-8 step function for the sensor frame
// CRC check and convert block. No dependencies.
package sfcc_pkg;

   // CRC-8, polynomial 0x31, initial value 0xFF, MSB first
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // Byte positions within a transfer
   localparam logic [2:0] POS_TEMP_MSB = 3'd0;
   localparam logic [2:0] POS_TEMP_LSB = 3'd1;
   localparam logic [2:0] POS_TEMP_CRC = 3'd2;
   localparam logic [2:0] POS_HUM_MSB  = 3'd3;
   localparam logic [2:0] POS_HUM_LSB  = 3'd4;
   localparam logic [2:0] POS_HUM_CRC  = 3'd5;
   localparam logic [2:0] GOOD_LENGTH  = 3'd6;
   localparam logic [2:0] COUNT_MAX    = 3'd7;

   // Conversion scales (hundredths) and offsets
   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [13:0] HUM_SCALE   = 14'd12500;
   localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
   localparam logic [16:0] TEMP_OFFSET = 17'd4500;
   localparam logic [15:0] HUM_OFFSET  = 16'd600;
   localparam logic [15:0] HUM_MAX     = 16'd10000;

   // Pending-result queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_LENGTH = 2'd1,
      STATUS_CRC    = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] temp_word;
      logic [15:0] hum_word;
   } job_type;

   // Queue handshake toward the back end
   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_out_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ hdl/sfcc_front.sv @@
// Front end: accepts transfer bytes, runs the CRC, assembles the words and
// classifies the transfer on its last byte. Depends on sfcc_pkg.
module sfcc_front import sfcc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  logic       end_of_transfer,
   output logic       push,
   output job_type    push_job
);

   logic [2:0]  byte_count_ff, byte_count_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] temp_word_ff, temp_word_in;
   logic [15:0] hum_word_ff, hum_word_in;
   logic        temp_good_ff, temp_good_in;
   logic        hum_good;

   always_comb begin
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      temp_word_in  = temp_word_ff;
      hum_word_in   = hum_word_ff;
      temp_good_in  = temp_good_ff;
      hum_good      = 1'b0;
      push          = 1'b0;
      push_job      = '{status: STATUS_OK, temp_word: temp_word_ff, hum_word: hum_word_ff};
      if (accept) begin
         unique case (byte_count_ff)
            POS_TEMP_MSB: begin
               crc_in       = crc8_update(crc_ff, rx_byte);
               temp_word_in = {rx_byte, temp_word_ff[7:0]};
            end
            POS_TEMP_LSB: begin
               crc_in       = crc8_update(crc_ff, rx_byte);
               temp_word_in = {temp_word_ff[15:8], rx_byte};
            end
            POS_TEMP_CRC: begin
               temp_good_in = (crc_ff == rx_byte);
               crc_in       = CRC_INIT;
            end
            POS_HUM_MSB: begin
               crc_in      = crc8_update(crc_ff, rx_byte);
               hum_word_in = {rx_byte, hum_word_ff[7:0]};
            end
            POS_HUM_LSB: begin
               crc_in      = crc8_update(crc_ff, rx_byte);
               hum_word_in = {hum_word_ff[15:8], rx_byte};
            end
            POS_HUM_CRC: begin
               hum_good = (crc_ff == rx_byte);
            end
            default: begin
            end
         endcase
         if (byte_count_ff != COUNT_MAX) begin
            byte_count_in = byte_count_ff + 3'd1;
         end
         if (end_of_transfer) begin
            push               = 1'b1;
            push_job.temp_word = temp_word_in;
            push_job.hum_word  = hum_word_in;
            if (byte_count_in != GOOD_LENGTH) begin
               push_job.status = STATUS_LENGTH;
            end else if (!temp_good_ff || !hum_good) begin
               push_job.status = STATUS_CRC;
            end else begin
               push_job.status = STATUS_OK;
            end
            // start the next transfer
            byte_count_in = '0;
            crc_in        = CRC_INIT;
            temp_good_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         crc_ff        <= CRC_INIT;
         temp_good_ff  <= 1'b0;
         temp_word_ff  <= '0;
         hum_word_ff   <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         temp_good_ff  <= temp_good_in;
         temp_word_ff  <= temp_word_in;
         hum_word_ff   <= hum_word_in;
      end
   end

endmodule

@@ hdl/sfcc_queue.sv @@
// Short queue of classified transfers between front and back end.
// Depends on sfcc_pkg.
module sfcc_queue import sfcc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  job_type       push_job,
   output logic          full,
   input  logic          pop,
   output queue_out_type head
);

   job_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = entry_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ hdl/sfcc_back.sv @@
// Back end: scales the words (multiply, divide by 65535, offset, clamp),
// keeps the held reading and drives the result register. Depends on sfcc_pkg.
module sfcc_back import sfcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  queue_out_type      head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_reading_valid,
   output logic [1:0]         rsp_status,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi
);

   logic advance;

   // stage 1: products
   logic        s1_valid_ff;
   status_type  s1_status_ff;
   logic [30:0] s1_prod_t_ff;
   logic [29:0] s1_prod_h_ff;

   // stage 2: quotient estimates and remainders
   logic        s2_valid_ff;
   status_type  s2_status_ff;
   logic [15:0] s2_est_t_ff, s2_est_h_ff;
   logic [16:0] s2_rem_t_ff, s2_rem_h_ff;
   logic [15:0] est_t_in, est_h_in;
   logic [16:0] rem_t_in, rem_h_in;

   // result register
   logic               out_valid_ff;
   logic               out_reading_ff;
   status_type         out_status_ff;
   logic signed [14:0] held_temp_ff, held_temp_in;
   logic [13:0]        held_hum_ff, held_hum_in;
   logic [15:0]        q_t, q_h, h_off;
   logic [16:0]        t_off;

   // the whole back end moves when the result register is free or being taken
   assign advance = !out_valid_ff || !rsp_stall;
   assign pop     = advance && head.valid;

   // x / 65535 estimate: (x + (x >> 16)) >> 16, never above, at most one below
   function automatic logic [15:0] div_est(input logic [30:0] x);
      logic [31:0] s;
      s = {1'b0, x} + {17'b0, x[30:16]};
      return s[31:16];
   endfunction

   function automatic logic [16:0] div_rem(input logic [30:0] x, input logic [15:0] q);
      logic [31:0] r;
      r = {1'b0, x} - {q, 16'b0} + {16'b0, q};
      return r[16:0];
   endfunction

   always_comb begin
      est_t_in = div_est(s1_prod_t_ff);
      est_h_in = div_est({1'b0, s1_prod_h_ff});
      rem_t_in = div_rem(s1_prod_t_ff, est_t_in);
      rem_h_in = div_rem({1'b0, s1_prod_h_ff}, est_h_in);
   end

   always_comb begin
      q_t = s2_est_t_ff + {15'b0, (s2_rem_t_ff >= {1'b0, FULL_SCALE})};
      q_h = s2_est_h_ff + {15'b0, (s2_rem_h_ff >= {1'b0, FULL_SCALE})};
      t_off = {1'b0, q_t} - TEMP_OFFSET;
      if (q_h < HUM_OFFSET) begin
         h_off = '0;
      end else begin
         h_off = q_h - HUM_OFFSET;
      end
      if (h_off > HUM_MAX) begin
         h_off = HUM_MAX;
      end
      held_temp_in = held_temp_ff;
      held_hum_in  = held_hum_ff;
      if (advance && s2_valid_ff && s2_status_ff == STATUS_OK) begin
         held_temp_in = signed'(t_off[14:0]);
         held_hum_in  = h_off[13:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         held_temp_ff <= '0;
         held_hum_ff  <= '0;
      end else begin
         if (advance) begin
            s1_valid_ff  <= head.valid;
            s2_valid_ff  <= s1_valid_ff;
            out_valid_ff <= s2_valid_ff;
         end
         held_temp_ff <= held_temp_in;
         held_hum_ff  <= held_hum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_status_ff   <= head.job.status;
         s1_prod_t_ff   <= 31'(head.job.temp_word) * 31'(TEMP_SCALE);
         s1_prod_h_ff   <= 30'(head.job.hum_word) * 30'(HUM_SCALE);
         s2_status_ff   <= s1_status_ff;
         s2_est_t_ff    <= est_t_in;
         s2_est_h_ff    <= est_h_in;
         s2_rem_t_ff    <= rem_t_in;
         s2_rem_h_ff    <= rem_h_in;
         out_status_ff  <= s2_status_ff;
         out_reading_ff <= (s2_status_ff == STATUS_OK);
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_reading_valid     = out_reading_ff;
   assign rsp_status            = out_status_ff;
   assign rsp_temperature_centi = held_temp_ff;
   assign rsp_humidity_centi    = held_hum_ff;

endmodule

@@ hdl/sensor_frame_crc_check_convert.sv @@
// Sensor frame CRC check and convert. Takes the bytes of a sensor read
// transfer one per cycle: temperature word (big-endian), its CRC-8 byte,
// humidity word, its CRC-8 byte; CRC-8 is polynomial 0x31, initial 0xFF,
// MSB first, and each word is checked on its own. The byte flagged with
// end_of_transfer closes the transfer and yields exactly one result item:
// status 1 if the byte count was not six (the count saturates at seven, and
// a length error wins over a CRC error), status 2 on a CRC mismatch, else
// status 0 with a new reading. Temperature is floor(17500*raw/65535)-4500
// hundredths of a degree C, humidity floor(12500*raw/65535)-600 hundredths
// of a percent clamped to 0..10000. Every result carries the latest good
// reading; a failed transfer repeats the previous one (zero after reset).
// Rate: one byte per cycle while req_stall is low. The closing byte's result
// is written into the pending-result queue, then passes the multiply stage,
// the divide-estimate stage and the result register; a stalled valid result
// in the result register holds them all.
// The queue holds four closed transfers; req_stall rises only while it is
// full, which takes a result side stalled for several transfers.
// Depends on sfcc_pkg, sfcc_front, sfcc_queue and sfcc_back.
module sensor_frame_crc_check_convert import sfcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // byte input
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_end_of_transfer,
   // result output
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_reading_valid,
   output logic [1:0]         rsp_status,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi
);

   logic          accept;
   logic          push;
   job_type       push_job;
   logic          queue_full;
   logic          pop;
   queue_out_type head;

   // hold off the byte source only while no room is left for a closed transfer
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // front end: CRC, word assembly and classification on the closing byte
   sfcc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .rx_byte         (req_rx_byte),
      .end_of_transfer (req_end_of_transfer),
      .push            (push),
      .push_job        (push_job)
   );

   // decouple the classifier from the conversion pipeline
   sfcc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head     (head)
   );

   // back end: scaling, held reading and result register
   sfcc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head                  (head),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_reading_valid     (rsp_reading_valid),
      .rsp_status            (rsp_status),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi)
   );

endmodule

@@ hdl/sfcc_checker.sv @@
// Port-level checker for the sensor frame CRC check and convert block, and
// the bind that attaches it. Depends on sfcc_pkg and the assertion macros.
`include "sensor_frame_crc_check_convert_assert.svh"

module sfcc_checker import sfcc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_reading_valid,
   input logic [1:0]         rsp_status,
   input logic signed [14:0] rsp_temperature_centi,
   input logic [13:0]        rsp_humidity_centi
);

   // a good reading is flagged exactly when the status says ok
   `SFCC_ASSERT(a_valid_matches_status, clock, reset,
      rsp_valid |-> (rsp_reading_valid == (rsp_status == STATUS_OK)))

   // while a result is valid, its held values stay in their converted ranges
   `SFCC_ASSERT(a_reading_range, clock, reset,
      rsp_valid |-> ((rsp_humidity_centi <= 14'd10000) &&
                     (rsp_temperature_centi >= -15'sd4500) &&
                     (rsp_temperature_centi <= 15'sd13000)))

   // a stalled result holds
   `SFCC_ASSERT(a_stalled_result_holds, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
                                 $stable(rsp_temperature_centi) && $stable(rsp_humidity_centi))

   // reset drops any pending result
   `SFCC_ASSERT_ALWAYS(a_reset_clears_output, clock, reset |=> !rsp_valid)

endmodule

bind sensor_frame_crc_check_convert sfcc_checker u_sfcc_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking bench for sensor_frame_crc_check_convert: byte stream driver,
// result monitor and a cycle-level frame decoder that predicts every result.
// Depends on sfcc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top import sfcc_pkg::*;;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned TAIL_CYCLES = 20;
   localparam int unsigned REPORT_MAX  = 10;
   localparam int unsigned RANDOM_BYTES = 2000;

   // Conversion constants, hundredths of a unit
   localparam int unsigned TEMP_SPAN   = 17500;
   localparam int unsigned HUM_SPAN    = 12500;
   localparam int unsigned RAW_FULL    = 65535;
   localparam int          TEMP_BIAS   = 4500;
   localparam int unsigned HUM_BIAS    = 600;
   localparam int unsigned HUM_CEILING = 10000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } bus_byte_type;

   typedef struct packed {
      logic        reading_valid;
      status_type  status;
      logic [14:0] temperature;
      logic [13:0] humidity;
   } reading_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_LONG,
      STALL_TOGGLE
   } stall_mode_type;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   // Block ports; every input starts at a known value
   logic               req_valid           = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte         = 8'h00;
   logic               req_end_of_transfer = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall           = 1'b0;
   logic               rsp_reading_valid;
   logic [1:0]         rsp_status;
   logic signed [14:0] rsp_temperature_centi;
   logic [13:0]        rsp_humidity_centi;

   sensor_frame_crc_check_convert dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .req_end_of_transfer   (req_end_of_transfer),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_reading_valid     (rsp_reading_valid),
      .rsp_status            (rsp_status),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi)
   );

   // Bytes waiting to go out, and readings the block still owes us
   bus_byte_type byte_queue[$];
   reading_type  pending_readings[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   logic        req_taken      = 1'b0;

   // Decoder state, mirrors what the block holds between bytes
   logic [2:0]  frame_pos       = 3'd0;
   logic [7:0]  frame_crc       = CRC_INIT;
   logic [15:0] temp_raw        = 16'h0000;
   logic [15:0] hum_raw         = 16'h0000;
   logic        temp_check_ok   = 1'b0;
   logic [14:0] last_temp_centi = 15'd0;
   logic [13:0] last_hum_centi  = 14'd0;

   // Sender burst/gap pacing
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;

   // Receiver stall pattern
   stall_mode_type stall_mode  = STALL_NONE;
   int unsigned    phase_left  = 0;
   int unsigned    run_left    = 0;
   logic           run_stalled = 1'b0;

   // CRC-8, poly 0x31, MSB first: shift one data bit at a time into the register
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      logic       feedback;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = acc[7] ^ data[i];
         acc = {acc[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [7:0] word_crc(input logic [15:0] word);
      return crc8_step(crc8_step(CRC_INIT, word[15:8]), word[7:0]);
   endfunction

   // Advance the decoder by one accepted byte; on the end mark, queue the reading
   task automatic decode_byte(input logic [7:0] data, input logic last);
      logic        hum_check_ok;
      int unsigned temp_scaled;
      int unsigned hum_scaled;
      reading_type reading;
      hum_check_ok = 1'b0;
      case (frame_pos)
         POS_TEMP_MSB: begin
            frame_crc = crc8_step(frame_crc, data);
            temp_raw[15:8] = data;
         end
         POS_TEMP_LSB: begin
            frame_crc = crc8_step(frame_crc, data);
            temp_raw[7:0] = data;
         end
         POS_TEMP_CRC: begin
            temp_check_ok = (frame_crc == data);
            frame_crc = CRC_INIT;
         end
         POS_HUM_MSB: begin
            frame_crc = crc8_step(frame_crc, data);
            hum_raw[15:8] = data;
         end
         POS_HUM_LSB: begin
            frame_crc = crc8_step(frame_crc, data);
            hum_raw[7:0] = data;
         end
         POS_HUM_CRC: begin
            hum_check_ok = (frame_crc == data);
         end
         default: begin
         end
      endcase
      // Saturate so an overlong transfer keeps reading as a length error
      if (frame_pos != COUNT_MAX) begin
         frame_pos = frame_pos + 3'd1;
      end
      if (last) begin
         if (frame_pos != GOOD_LENGTH) begin
            reading.status = STATUS_LENGTH;
         end else if (!temp_check_ok || !hum_check_ok) begin
            reading.status = STATUS_CRC;
         end else begin
            reading.status = STATUS_OK;
            temp_scaled = (TEMP_SPAN * int'(temp_raw)) / RAW_FULL;
            hum_scaled  = (HUM_SPAN * int'(hum_raw)) / RAW_FULL;
            last_temp_centi = 15'(int'(temp_scaled) - TEMP_BIAS);
            if (hum_scaled < HUM_BIAS) begin
               hum_scaled = 0;
            end else begin
               hum_scaled = hum_scaled - HUM_BIAS;
            end
            if (hum_scaled > HUM_CEILING) begin
               hum_scaled = HUM_CEILING;
            end
            last_hum_centi = 14'(hum_scaled);
         end
         reading.reading_valid = (reading.status == STATUS_OK);
         reading.temperature   = last_temp_centi;
         reading.humidity      = last_hum_centi;
         pending_readings.push_back(reading);
         // Start over; the raw words keep their bits
         frame_pos     = 3'd0;
         frame_crc     = CRC_INIT;
         temp_check_ok = 1'b0;
      end
   endtask

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   task automatic push_byte(input logic [7:0] data, input logic last);
      bus_byte_type b;
      b.data = data;
      b.last = last;
      byte_queue.push_back(b);
   endtask

   // Queue one six-byte frame; flip masks corrupt the CRC bytes, extra bytes
   // run the transfer past its proper length
   task automatic push_frame(input logic [15:0] temp, input logic [15:0] hum,
                             input logic [7:0] temp_flip, input logic [7:0] hum_flip,
                             input int unsigned extra);
      logic [7:0] frame [6];
      frame[0] = temp[15:8];
      frame[1] = temp[7:0];
      frame[2] = word_crc(temp) ^ temp_flip;
      frame[3] = hum[15:8];
      frame[4] = hum[7:0];
      frame[5] = word_crc(hum) ^ hum_flip;
      for (int i = 0; i < 6; i++) begin
         push_byte(frame[i], (extra == 0) && (i == 5));
      end
      for (int i = 0; i < extra; i++) begin
         push_byte(8'($urandom_range(0, 255)), i == extra - 1);
      end
   endtask

   // Pick a raw word: mostly uniform, sometimes near a conversion corner
   function automatic logic [15:0] pick_word(input logic for_humidity);
      case ($urandom_range(0, 7))
         0: return for_humidity ? 16'($urandom_range(3100, 3200)) : 16'($urandom_range(0, 40));
         1: return for_humidity ? 16'($urandom_range(55500, 55650))
                                : 16'($urandom_range(16800, 16900));
         2: return 16'($urandom_range(65490, 65535));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Sampling side: check results first, then advance the decoder, so a
   // reading can never be matched against the byte that closes it this cycle
   always @(posedge clock) begin : result_monitor
      reading_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (pending_readings.size() == 0) begin
               flag_mismatch($sformatf("result with nothing pending (status %0d)", rsp_status));
            end else begin
               want = pending_readings.pop_front();
               if (rsp_reading_valid !== want.reading_valid) begin
                  flag_mismatch($sformatf("reading_valid exp %0b got %0b",
                                          want.reading_valid, rsp_reading_valid));
               end
               if (rsp_status !== want.status) begin
                  flag_mismatch($sformatf("status exp %0d got %0d", want.status, rsp_status));
               end
               if (rsp_temperature_centi !== want.temperature) begin
                  flag_mismatch($sformatf("temperature_centi exp %0d got %0d",
                                          $signed(want.temperature), rsp_temperature_centi));
               end
               if (rsp_humidity_centi !== want.humidity) begin
                  flag_mismatch($sformatf("humidity_centi exp %0d got %0d",
                                          want.humidity, rsp_humidity_centi));
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_rx_byte, req_end_of_transfer);
         end
      end
   end

   // Byte driver: changes on the falling edge only. Hold the current item
   // until it is taken, then either idle for the gap or present the next one.
   always @(negedge clock) begin : byte_driver
      bus_byte_type nxt;
      logic         drive_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         drive_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (byte_queue.size() > 0) begin
            nxt = byte_queue.pop_front();
            req_rx_byte         <= nxt.data;
            req_end_of_transfer <= nxt.last;
            drive_valid = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else if ($urandom_range(0, 3) == 0) begin
               // long stretch with no idling at all
               burst_left = $urandom_range(40, 200);
               gap_left   = 0;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left   = $urandom_range(1, 8);
            end
         end
         req_valid <= drive_valid;
      end
   end

   // Result-side stall: switch to a randomly chosen pattern whenever a phase runs out.
   // Long stall runs let the block's pending-result queue fill and push back.
   always @(negedge clock) begin : stall_pattern
      logic hold;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (phase_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            phase_left = $urandom_range(30, 300);
         end else begin
            phase_left--;
         end
         case (stall_mode)
            STALL_RANDOM: hold = ($urandom_range(0, 2) == 0);
            STALL_LONG: begin
               if (run_left == 0) begin
                  run_stalled = !run_stalled;
                  run_left = run_stalled ? $urandom_range(5, 40) : $urandom_range(1, 6);
               end else begin
                  run_left--;
               end
               hold = run_stalled;
            end
            STALL_TOGGLE: hold = !rsp_stall;
            default: hold = 1'b0;
         endcase
         rsp_stall <= hold;
      end
   end

   // Watchdog: fail the run once the cycle count reaches CYCLE_LIMIT
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned random_start;
      int unsigned pick;
      int unsigned len;
      logic [7:0]  temp_flip;
      logic [7:0]  hum_flip;

      // Directed: both raw extremes (cold with dry clamp, hot with wet clamp), a bad
      // humidity CRC, a one-byte transfer, and an overlong transfer that also
      // carries a bad CRC so the length error has to win
      push_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 0);
      push_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 0);
      push_frame(16'h8000, 16'h1234, 8'h00, 8'h01, 0);
      push_byte(8'hA5, 1'b1);
      push_frame(16'h6666, 16'h9999, 8'h80, 8'h00, 1);

      // Random: mostly clean frames, mixed with CRC damage, short and long transfers
      random_start = byte_queue.size();
      while (byte_queue.size() - random_start < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            push_frame(pick_word(1'b0), pick_word(1'b1), 8'h00, 8'h00, 0);
         end else if (pick < 85) begin
            temp_flip = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
            hum_flip  = (temp_flip == 8'h00) ? 8'($urandom_range(1, 255))
                                             : 8'($urandom_range(0, 255));
            push_frame(pick_word(1'b0), pick_word(1'b1), temp_flip, hum_flip, 0);
         end else if (pick < 93) begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) begin
               push_byte(8'($urandom_range(0, 255)), i == len - 1);
            end
         end else begin
            push_frame(pick_word(1'b0), pick_word(1'b1), 8'h00, 8'h00, $urandom_range(1, 6));
         end
      end

      // Hold reset, then release it on a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: all bytes out, every reading back, then a short tail
      while (byte_queue.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (pending_readings.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_readings.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/sfcc_pkg.sv
hdl/sfcc_front.sv
hdl/sfcc_queue.sv
hdl/sfcc_back.sv
hdl/sensor_frame_crc_check_convert.sv
hdl/sfcc_checker.sv
tb/tb_top.sv
